// File: src/ced_pkg.sv
// Shared types and constants of the edge detector.
`timescale 1ns / 1ps

package ced_pkg;

  localparam int PIX_W      = 8;
  localparam int DIFF_W     = 11;
  localparam int ABS_W      = 10;
  localparam int MAG_W      = 21;
  localparam int THR_W      = 11;
  localparam int THR2_W     = 22;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int PROD_W     = 27;

  // tan(22.5) and tan(67.5) in Q15
  localparam logic [PROD_W-1:0] TAN_LO_Q15 = 27'd13573;
  localparam logic [PROD_W-1:0] TAN_HI_Q15 = 27'd79109;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 8'd3;

  localparam logic [THR2_W-1:0] LOW_THR2_RST  = 22'd900;
  localparam logic [THR2_W-1:0] HIGH_THR2_RST = 22'd10000;
  localparam logic [FW_W-1:0]   FRAME_W_RST   = 11'd640;
  localparam logic [FH_W-1:0]   FRAME_H_RST   = 13'd480;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

  // Gradient direction sectors
  localparam logic [1:0] SEC_HORZ = 2'd0;
  localparam logic [1:0] SEC_D45  = 2'd1;
  localparam logic [1:0] SEC_VERT = 2'd2;
  localparam logic [1:0] SEC_D135 = 2'd3;

  typedef struct packed {
    logic [1:0]       sec;
    logic [MAG_W-1:0] mag;
  } grad_t;

  // Which sides of a window centre lie on the image border
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } brd_t;

endpackage

// File: src/ced_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ced_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/canny_edge_detector_top.sv
// Top level of the streaming Canny edge detector.
`timescale 1ns / 1ps

// Streaming Canny edge detector: one 8-bit pixel in and, once the window has filled, one edge
// pixel out per transaction, one transaction per clock when the output is not stalled. A frame
// takes W*H pixels followed by 3*W+3 further transactions (flush or pixel) that drain it; the
// result for raster position p comes with input transaction p+3*W+3 and passes through the
// three line-buffer stages (Sobel, suppression, threshold), each a RAM with a registered read,
// plus the arithmetic stages between them, into the output register. Frame size is
// taken at the first pixel of a frame; thresholds act at once. The line buffers need no
// clearing pass: border handling never reads a position that the current frame has not written.
module canny_edge_detector_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [ced_pkg::PIX_W-1:0]      in_pixel_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ced_pkg::PIX_W-1:0]      out_edge_value,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ced_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CIDX_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
  localparam int NSTG   = 8;
  localparam int GW     = $bits(ced_pkg::grad_t);

  typedef struct packed {
    logic [ced_pkg::PIX_W-1:0] pix;
    logic                      wen;
    logic [CIDX_W-1:0]         ic;
    logic [CIDX_W-1:0]         ac;
    ced_pkg::brd_t             a_brd;
    logic [CIDX_W-1:0]         bc;
    ced_pkg::brd_t             b_brd;
    logic                      c_res;
    ced_pkg::brd_t             c_brd;
    logic                      last;
  } tick_t;

  // ---------------- configuration ----------------
  logic [ced_pkg::THR2_W-1:0] low_thr2_r, high_thr2_r;
  logic [ced_pkg::FW_W-1:0]   frame_w_r;
  logic [ced_pkg::FH_W-1:0]   frame_h_r;
  logic [ced_pkg::THR2_W-1:0] cfg_sq;

  assign cfg_ready = 1'b1;
  assign cfg_sq = ced_pkg::THR2_W'(cfg_data[ced_pkg::THR_W-1:0])
                * ced_pkg::THR2_W'(cfg_data[ced_pkg::THR_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr2_r  <= ced_pkg::LOW_THR2_RST;
      high_thr2_r <= ced_pkg::HIGH_THR2_RST;
      frame_w_r   <= ced_pkg::FRAME_W_RST;
      frame_h_r   <= ced_pkg::FRAME_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ced_pkg::REG_LOW_THR:  low_thr2_r  <= cfg_sq;
        ced_pkg::REG_HIGH_THR: high_thr2_r <= cfg_sq;
        ced_pkg::REG_FRAME_W:  frame_w_r   <= cfg_data[ced_pkg::FW_W-1:0];
        ced_pkg::REG_FRAME_H:  frame_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- frame sequencing ----------------
  logic              fr_act_r, in_done_r, a_run_r, b_run_r, c_run_r;
  logic [ROW_W-1:0]  ir_r, ar_r, br_r, cr_r, hm1_r;
  logic [CIDX_W-1:0] ic_r, ac_r, bc_r, cc_r, wm1_r;

  logic [COL_W-1:0]  sat_w;
  logic [ROW_W-1:0]  sat_h;
  logic              start, tick, acc, adv;
  logic              done_c, a_run_c, b_run_c, c_run_c, wen, a_go, b_go, c_go, last;
  logic [ROW_W-1:0]  ir_c, ar_c, br_c, cr_c, hm1_c;
  logic [CIDX_W-1:0] ic_c, ac_c, bc_c, cc_c, wm1_c;
  tick_t             tk;

  always_comb begin
    if (frame_w_r < ced_pkg::FW_W'(3)) begin
      sat_w = COL_W'(3);
    end else if (32'(frame_w_r) > MAX_WIDTH) begin
      sat_w = COL_W'(MAX_WIDTH);
    end else begin
      sat_w = COL_W'(frame_w_r);
    end
    if (frame_h_r < ced_pkg::FH_W'(3)) begin
      sat_h = ROW_W'(3);
    end else if (32'(frame_h_r) > MAX_HEIGHT) begin
      sat_h = ROW_W'(MAX_HEIGHT);
    end else begin
      sat_h = ROW_W'(frame_h_r);
    end
  end

  assign acc   = in_valid && in_ready;
  assign start = !fr_act_r && !in_req_type;
  // Flushes are ignored between frames and while pixels are still due.
  assign tick  = start || (fr_act_r && (in_done_r || !in_req_type));

  always_comb begin
    wm1_c   = start ? CIDX_W'(sat_w - COL_W'(1)) : wm1_r;
    hm1_c   = start ? (sat_h - ROW_W'(1)) : hm1_r;
    done_c  = start ? 1'b0 : in_done_r;
    a_run_c = start ? 1'b0 : a_run_r;
    b_run_c = start ? 1'b0 : b_run_r;
    c_run_c = start ? 1'b0 : c_run_r;
    ir_c    = start ? '0 : ir_r;
    ic_c    = start ? '0 : ic_r;
    ar_c    = start ? '0 : ar_r;
    ac_c    = start ? '0 : ac_r;
    br_c    = start ? '0 : br_r;
    bc_c    = start ? '0 : bc_r;
    cr_c    = start ? '0 : cr_r;
    cc_c    = start ? '0 : cc_r;
    wen     = !done_c;
    // Each stage's window centre trails the one before it by one row and one column.
    a_go    = a_run_c || (wen && ir_c == ROW_W'(1) && ic_c == CIDX_W'(1));
    b_go    = b_run_c || (a_go && ar_c == ROW_W'(1) && ac_c == CIDX_W'(1));
    c_go    = c_run_c || (b_go && br_c == ROW_W'(1) && bc_c == CIDX_W'(1));
    last    = c_go && cr_c == hm1_c && cc_c == wm1_c;

    tk.pix   = in_pixel_value;
    tk.wen   = wen;
    tk.ic    = ic_c;
    tk.ac    = ac_c;
    tk.a_brd = '{top: ar_c == '0, bot: ar_c == hm1_c, lft: ac_c == '0, rgt: ac_c == wm1_c};
    tk.bc    = bc_c;
    tk.b_brd = '{top: br_c == '0, bot: br_c == hm1_c, lft: bc_c == '0, rgt: bc_c == wm1_c};
    tk.c_res = c_go;
    tk.c_brd = '{top: cr_c == '0, bot: cr_c == hm1_c, lft: cc_c == '0, rgt: cc_c == wm1_c};
    tk.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_act_r  <= 1'b0;
      in_done_r <= 1'b0;
      a_run_r   <= 1'b0;
      b_run_r   <= 1'b0;
      c_run_r   <= 1'b0;
      ir_r      <= '0;
      ic_r      <= '0;
      ar_r      <= '0;
      ac_r      <= '0;
      br_r      <= '0;
      bc_r      <= '0;
      cr_r      <= '0;
      cc_r      <= '0;
      wm1_r     <= '0;
      hm1_r     <= '0;
    end else if (acc && tick) begin
      wm1_r <= wm1_c;
      hm1_r <= hm1_c;
      if (last) begin
        fr_act_r  <= 1'b0;
        in_done_r <= 1'b0;
        a_run_r   <= 1'b0;
        b_run_r   <= 1'b0;
        c_run_r   <= 1'b0;
        ir_r      <= '0;
        ic_r      <= '0;
        ar_r      <= '0;
        ac_r      <= '0;
        br_r      <= '0;
        bc_r      <= '0;
        cr_r      <= '0;
        cc_r      <= '0;
      end else begin
        fr_act_r  <= 1'b1;
        in_done_r <= done_c || (wen && ir_c == hm1_c && ic_c == wm1_c);
        a_run_r   <= a_go;
        b_run_r   <= b_go;
        c_run_r   <= c_go;
        ir_r      <= (wen && ic_c == wm1_c) ? ir_c + ROW_W'(1) : ir_c;
        // The read column keeps moving while draining so the last row's windows are fetched.
        ic_r      <= (ic_c == wm1_c) ? '0 : ic_c + CIDX_W'(1);
        ar_r      <= (a_go && ac_c == wm1_c) ? ar_c + ROW_W'(1) : ar_c;
        ac_r      <= !a_go ? ac_c : (ac_c == wm1_c) ? '0 : ac_c + CIDX_W'(1);
        br_r      <= (b_go && bc_c == wm1_c) ? br_c + ROW_W'(1) : br_c;
        bc_r      <= !b_go ? bc_c : (bc_c == wm1_c) ? '0 : bc_c + CIDX_W'(1);
        cr_r      <= (c_go && cc_c == wm1_c) ? cr_c + ROW_W'(1) : cr_c;
        cc_r      <= !c_go ? cc_c : (cc_c == wm1_c) ? '0 : cc_c + CIDX_W'(1);
      end
    end
  end

  // ---------------- pipeline control ----------------
  tick_t            pipe_r [NSTG];
  logic [NSTG-1:0]  pv_r;
  logic             out_valid_r, out_last_r, out_load;
  logic [ced_pkg::PIX_W-1:0] out_edge_r;

  // The pipeline only halts when a result reaches the end while the output is still occupied.
  assign adv      = !(out_valid_r && !out_ready && pv_r[NSTG-1] && pipe_r[NSTG-1].c_res);
  assign in_ready = adv;
  assign out_load = adv && pv_r[NSTG-1] && pipe_r[NSTG-1].c_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (adv) begin
      pv_r <= {pv_r[NSTG-2:0], acc && tick};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= tk;
      for (int i = 1; i < NSTG; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  // ---------------- Sobel stage ----------------
  logic [2*ced_pkg::PIX_W-1:0] rd_a;
  logic [ced_pkg::PIX_W-1:0]   wa_r [0:2][0:2];
  logic [ced_pkg::PIX_W-1:0]   sa   [0:2][0:2];
  logic [ced_pkg::PIX_W+1:0]   sum_l, sum_r, sum_t, sum_b;
  logic signed [ced_pkg::DIFF_W-1:0] dx_r, dy_r;
  ced_pkg::brd_t ba;

  ced_ram #(.WIDTH(2 * ced_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_pix_ram (
    .clk     (clk),
    .wr_en   (adv && pv_r[1] && pipe_r[1].wen),
    .wr_addr (pipe_r[1].ic),
    .wr_data ({rd_a[ced_pkg::PIX_W-1:0], pipe_r[1].pix}),
    .rd_en   (adv),
    .rd_addr (pipe_r[0].ic),
    .rd_data (rd_a)
  );

  always_ff @(posedge clk) begin
    if (adv && pv_r[1]) begin
      wa_r[0] <= wa_r[1];
      wa_r[1] <= wa_r[2];
      wa_r[2] <= '{rd_a[2*ced_pkg::PIX_W-1:ced_pkg::PIX_W], rd_a[ced_pkg::PIX_W-1:0],
                   pipe_r[1].pix};
    end
  end

  // Reflect-101 borders: the missing column or row is replaced by its mirror.
  always_comb begin
    ba = pipe_r[2].a_brd;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        sa[j][i] = wa_r[j][i];
      end
    end
    if (ba.lft) begin
      sa[0] = wa_r[2];
    end
    if (ba.rgt) begin
      sa[2] = wa_r[0];
    end
    for (int j = 0; j < 3; j++) begin
      if (ba.top) begin
        sa[j][0] = ba.lft && j == 0 ? wa_r[2][2] : ba.rgt && j == 2 ? wa_r[0][2] : wa_r[j][2];
      end
      if (ba.bot) begin
        sa[j][2] = ba.lft && j == 0 ? wa_r[2][0] : ba.rgt && j == 2 ? wa_r[0][0] : wa_r[j][0];
      end
    end
    sum_l = 10'(sa[0][0]) + {1'b0, sa[0][1], 1'b0} + 10'(sa[0][2]);
    sum_r = 10'(sa[2][0]) + {1'b0, sa[2][1], 1'b0} + 10'(sa[2][2]);
    sum_t = 10'(sa[0][0]) + {1'b0, sa[1][0], 1'b0} + 10'(sa[2][0]);
    sum_b = 10'(sa[0][2]) + {1'b0, sa[1][2], 1'b0} + 10'(sa[2][2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
      dy_r <= $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    end
  end

  // ---------------- magnitude and direction ----------------
  logic signed [ced_pkg::DIFF_W-1:0] fx, fy;
  logic [ced_pkg::ABS_W-1:0]  ax, ay;
  logic [ced_pkg::PROD_W-1:0] tan_a, tan_lo, tan_hi;
  ced_pkg::grad_t grad_nxt, grad_r;

  always_comb begin
    // Fold the direction into the upper half plane.
    fx = dy_r < 0 ? -dx_r : dx_r;
    fy = dy_r < 0 ? -dy_r : dy_r;
    ax = fx < 0 ? ced_pkg::ABS_W'(-fx) : ced_pkg::ABS_W'(fx);
    ay = ced_pkg::ABS_W'(fy);
    tan_a  = {2'b00, ay, 15'd0};
    tan_lo = ced_pkg::PROD_W'(ax) * ced_pkg::TAN_LO_Q15;
    tan_hi = ced_pkg::PROD_W'(ax) * ced_pkg::TAN_HI_Q15;
    if (fx >= 0) begin
      grad_nxt.sec = tan_a <= tan_lo ? ced_pkg::SEC_HORZ :
                     tan_a <= tan_hi ? ced_pkg::SEC_D45 : ced_pkg::SEC_VERT;
    end else begin
      grad_nxt.sec = tan_a < tan_lo ? ced_pkg::SEC_HORZ :
                     tan_a < tan_hi ? ced_pkg::SEC_D135 : ced_pkg::SEC_VERT;
    end
    grad_nxt.mag = ced_pkg::MAG_W'(ax) * ced_pkg::MAG_W'(ax)
                 + ced_pkg::MAG_W'(ay) * ced_pkg::MAG_W'(ay);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad_r <= grad_nxt;
    end
  end

  // ---------------- non-maximum suppression ----------------
  logic [2*GW-1:0]            rd_b;
  ced_pkg::grad_t             gb_r [0:2][0:2];
  logic [ced_pkg::MAG_W-1:0]  mk   [0:2][0:2];
  logic [ced_pkg::MAG_W-1:0]  nb_a, nb_b, nm_c, nms_r;
  ced_pkg::brd_t bb;

  ced_ram #(.WIDTH(2 * GW), .DEPTH(MAX_WIDTH)) u_grad_ram (
    .clk     (clk),
    .wr_en   (adv && pv_r[4]),
    .wr_addr (pipe_r[4].ac),
    .wr_data ({rd_b[GW-1:0], grad_r}),
    .rd_en   (adv),
    .rd_addr (pipe_r[3].ac),
    .rd_data (rd_b)
  );

  always_ff @(posedge clk) begin
    if (adv && pv_r[4]) begin
      gb_r[0] <= gb_r[1];
      gb_r[1] <= gb_r[2];
      gb_r[2] <= '{rd_b[2*GW-1:GW], rd_b[GW-1:0], grad_r};
    end
  end

  // Neighbours outside the image count as zero.
  always_comb begin
    bb = pipe_r[5].b_brd;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        mk[j][i] = ((i == 0 && bb.top) || (i == 2 && bb.bot) ||
                    (j == 0 && bb.lft) || (j == 2 && bb.rgt)) ? '0 : gb_r[j][i].mag;
      end
    end
    case (gb_r[1][1].sec)
      ced_pkg::SEC_HORZ: begin
        nb_a = mk[2][1];
        nb_b = mk[0][1];
      end
      ced_pkg::SEC_D45: begin
        nb_a = mk[2][2];
        nb_b = mk[0][0];
      end
      ced_pkg::SEC_VERT: begin
        nb_a = mk[1][2];
        nb_b = mk[1][0];
      end
      default: begin
        nb_a = mk[0][2];
        nb_b = mk[2][0];
      end
    endcase
    nm_c = gb_r[1][1].mag;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nms_r <= (nm_c < nb_a || nm_c < nb_b) ? '0 : nm_c;
    end
  end

  // ---------------- double threshold ----------------
  logic [2*ced_pkg::MAG_W-1:0] rd_c;
  logic [ced_pkg::MAG_W-1:0]   nc_r [0:2][0:2];
  logic [ced_pkg::PIX_W-1:0]   edge_nxt;
  logic                        any_strong;
  ced_pkg::brd_t bc;

  ced_ram #(.WIDTH(2 * ced_pkg::MAG_W), .DEPTH(MAX_WIDTH)) u_nms_ram (
    .clk     (clk),
    .wr_en   (adv && pv_r[6]),
    .wr_addr (pipe_r[6].bc),
    .wr_data ({rd_c[ced_pkg::MAG_W-1:0], nms_r}),
    .rd_en   (adv),
    .rd_addr (pipe_r[5].bc),
    .rd_data (rd_c)
  );

  always_ff @(posedge clk) begin
    if (adv && pv_r[6]) begin
      nc_r[0] <= nc_r[1];
      nc_r[1] <= nc_r[2];
      nc_r[2] <= '{rd_c[2*ced_pkg::MAG_W-1:ced_pkg::MAG_W], rd_c[ced_pkg::MAG_W-1:0], nms_r};
    end
  end

  always_comb begin
    bc = pipe_r[NSTG-1].c_brd;
    any_strong = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (!(i == 1 && j == 1) &&
            !((i == 0 && bc.top) || (i == 2 && bc.bot) ||
              (j == 0 && bc.lft) || (j == 2 && bc.rgt)) &&
            {1'b0, nc_r[j][i]} > high_thr2_r) begin
          any_strong = 1'b1;
        end
      end
    end
    if ({1'b0, nc_r[1][1]} > high_thr2_r) begin
      edge_nxt = ced_pkg::EDGE_ON;
    end else if ({1'b0, nc_r[1][1]} < low_thr2_r) begin
      edge_nxt = ced_pkg::EDGE_OFF;
    end else begin
      edge_nxt = any_strong ? ced_pkg::EDGE_ON : ced_pkg::EDGE_OFF;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_edge_r <= edge_nxt;
      out_last_r <= pipe_r[NSTG-1].last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = out_edge_r;
  assign out_frame_last = out_last_r;

  // ---------------- assertions ----------------
  a_edge_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_edge_r == ced_pkg::EDGE_ON || out_edge_r == ced_pkg::EDGE_OFF))
    else $error("edge pixel neither 0 nor 255");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !fr_act_r |-> (!in_done_r && !a_run_r && !b_run_r && !c_run_r))
    else $error("frame sequencing state left over between frames");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    c_run_r |-> (b_run_r && a_run_r))
    else $error("later stage running before an earlier one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> (out_valid_r && pv_r[NSTG-1] && pipe_r[NSTG-1].c_res))
    else $error("pipeline halted without a waiting result");

endmodule
